/* rtl/htb_pkg.sv */
package htb_pkg;

    localparam int HEAP_DEPTH      = 256;
    localparam int NODE_DEPTH      = 512;
    localparam int HEAP_AW         = 8;
    localparam int NODE_AW         = 9;
    localparam int HCNT_W          = 9;
    localparam int NCNT_W          = 10;
    localparam int FREQ_W          = 40;
    localparam int SYM_W           = 8;
    localparam int DEF_MAX_LEAVES  = 256;
    localparam int DEF_WEIGHT_BITS = 48;

    localparam logic OP_FREQ     = 1'b0;
    localparam logic OP_BIT      = 1'b1;
    localparam logic KIND_BUILD  = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;

    localparam logic [1:0] STATUS_BUILT   = 2'd0;
    localparam logic [1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [1:0] STATUS_DROPPED = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_BUILD,
        S_POP_RD,
        S_POP_LD,
        S_SD_RD,
        S_SD_CMP,
        S_MERGE,
        S_DEC_NX,
        S_DEC_LF,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        POP_A,
        POP_B,
        POP_ROOT
    } pop_t;

    typedef struct packed {
        logic                 leaf;
        logic [SYM_W-1:0]     sym;
        logic [NODE_AW-1:0]   left;
        logic [NODE_AW-1:0]   right;
    } node_t;

    typedef struct packed {
        logic                 we;
        logic [HEAP_AW-1:0]   waddr;
        logic [HEAP_AW-1:0]   raddr_a;
        logic [HEAP_AW-1:0]   raddr_b;
    } heap_ctl_t;

endpackage

/* rtl/huffman_tree_build_decode.sv */
// Huffman tree builder and bit-serial decoder for byte symbols.
// Input channel (in_valid / in_stall): operation 0 loads a (symbol, frequency)
// entry, zero counts are skipped; an entry with last set starts the tree build.
// operation 1 feeds one coded bit (0 left, 1 right); last on a bit ends the
// stream and returns the walk to the root.
// Output channel (out_valid / out_stall): result_kind 0 reports build_status
// (0 built, 1 empty load, 2 leaves over capacity dropped), result_kind 1 a
// decoded symbol. Bits with no built tree give no result.
// Timing: one item at a time. A leaf entry is sifted up through the
// single-write heap memory; the build runs a pop/sift-down/push loop on the
// heap memory. A coded bit takes two dependent node-memory reads (the current
// node, then its child); when the tree is a single leaf the bit goes straight
// to the output.
// in_stall is high whenever an item is in progress. A finished result sits in
// the output register; the next item is accepted meanwhile, and a further
// result waits until the receiver drops out_stall.
// Reset clears all control state: no tree, next entry starts a fresh load.
// Heap and node memories need no clearing pass.
module huffman_tree_build_decode
    import htb_pkg::*;
#(
    parameter int MAX_LEAVES  = DEF_MAX_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [FREQ_W-1:0] frequency,
    input  logic              coded_bit,
    input  logic              last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              result_kind,
    output logic [1:0]        build_status,
    output logic [SYM_W-1:0]  decoded_symbol
);

    localparam int HE_W = WEIGHT_BITS + NODE_AW;
    localparam int EXT_W = (WEIGHT_BITS > FREQ_W) ? WEIGHT_BITS : FREQ_W;

    state_t               state_reg, state_next;
    pop_t                 pop_reg, pop_next;
    logic [HCNT_W-1:0]    hc_reg, hc_next;
    logic [NCNT_W-1:0]    nc_reg, nc_next;
    logic [NODE_AW-1:0]   root_reg, root_next;
    logic [NODE_AW-1:0]   walk_reg, walk_next;
    logic [NODE_AW-1:0]   nxt_reg, nxt_next;
    logic                 tree_ready_reg, tree_ready_next;
    logic                 loading_reg, loading_next;
    logic                 cap_reg, cap_next;
    logic                 building_reg, building_next;
    logic                 root_leaf_reg, root_leaf_next;
    logic [SYM_W-1:0]     leaf_sym_reg, leaf_sym_next;
    logic                 bit_reg, bit_next;
    logic                 lastb_reg, lastb_next;
    logic [HEAP_AW-1:0]   idx_reg, idx_next;
    logic [HE_W-1:0]      val_reg, val_next;
    logic [HE_W-1:0]      top_reg, top_next;
    logic [HE_W-1:0]      a_reg, a_next;
    logic                 res_kind_reg, res_kind_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [SYM_W-1:0]     res_sym_reg, res_sym_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [1:0]           out_status_reg, out_status_next;
    logic [SYM_W-1:0]     out_sym_reg, out_sym_next;

    heap_ctl_t            heap_ctl;
    logic [HE_W-1:0]      heap_wdata;
    logic [HE_W-1:0]      heap_rd_a;
    logic [HE_W-1:0]      heap_rd_b;

    node_t                node_mem [NODE_DEPTH];
    node_t                node_rd;
    node_t                node_wdata;
    logic                 node_we;
    logic [NODE_AW-1:0]   node_waddr;
    logic [NODE_AW-1:0]   node_raddr;

    logic                 acc;
    logic                 out_free;
    logic [HCNT_W-1:0]    hc_eff;
    logic [NCNT_W-1:0]    nc_eff;
    logic                 do_leaf;
    logic [EXT_W-1:0]     freq_ext;
    logic [EXT_W-1:0]     wmax_ext;
    logic [WEIGHT_BITS-1:0] freq_w;
    logic [HEAP_AW-1:0]   idx_m1;
    logic [HEAP_AW-1:0]   parent;
    logic [NCNT_W-1:0]    sd_l;
    logic [NCNT_W-1:0]    sd_r;
    logic                 sd_leaf;
    logic [WEIGHT_BITS-1:0] val_w;
    logic [WEIGHT_BITS-1:0] wa;
    logic [WEIGHT_BITS-1:0] wb;
    logic [WEIGHT_BITS-1:0] smin;
    logic                 sel_l;
    logic                 sel_r;
    logic                 push_up;
    logic                 push_done;
    logic                 pop_done;
    logic [WEIGHT_BITS:0] sum_ext;
    logic [WEIGHT_BITS-1:0] sum_w;
    logic [NODE_AW-1:0]   child;

    htb_heap_mem #(.ENTRY_W(HE_W)) u_heap (
        .clk     (clk),
        .ctl     (heap_ctl),
        .wdata   (heap_wdata),
        .rdata_a (heap_rd_a),
        .rdata_b (heap_rd_b)
    );

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd <= node_mem[node_raddr];
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign acc            = in_valid && !in_stall;
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign result_kind    = out_kind_reg;
    assign build_status   = out_status_reg;
    assign decoded_symbol = out_sym_reg;

    assign hc_eff   = loading_reg ? hc_reg : '0;
    assign nc_eff   = loading_reg ? nc_reg : '0;
    assign do_leaf  = (frequency != '0) && (nc_eff < NCNT_W'(MAX_LEAVES));
    assign freq_ext = EXT_W'(frequency);
    assign wmax_ext = EXT_W'({WEIGHT_BITS{1'b1}});
    assign freq_w   = WEIGHT_BITS'((freq_ext > wmax_ext) ? wmax_ext : freq_ext);

    assign idx_m1  = idx_reg - HEAP_AW'(1);
    assign parent  = {1'b0, idx_m1[HEAP_AW-1:1]};
    assign sd_l    = {1'b0, idx_reg, 1'b1};
    assign sd_r    = sd_l + NCNT_W'(1);
    assign sd_leaf = sd_l >= NCNT_W'(hc_reg);

    assign val_w = val_reg[HE_W-1:NODE_AW];
    assign wa    = heap_rd_a[HE_W-1:NODE_AW];
    assign wb    = heap_rd_b[HE_W-1:NODE_AW];
    assign sel_l = wa < val_w;
    assign smin  = sel_l ? wa : val_w;
    assign sel_r = (sd_r < NCNT_W'(hc_reg)) && (wb < smin);

    assign push_up   = (state_reg == S_PUSH_CMP) && (val_w < wa);
    assign push_done = ((state_reg == S_PUSH_CHK) && (idx_reg == '0))
                    || ((state_reg == S_PUSH_CMP) && !push_up);
    assign pop_done  = ((state_reg == S_SD_RD) && sd_leaf)
                    || ((state_reg == S_SD_CMP) && !sel_l && !sel_r);

    assign sum_ext = {1'b0, a_reg[HE_W-1:NODE_AW]} + {1'b0, top_reg[HE_W-1:NODE_AW]};
    assign sum_w   = sum_ext[WEIGHT_BITS] ? {WEIGHT_BITS{1'b1}} : sum_ext[WEIGHT_BITS-1:0];
    assign child   = bit_reg ? node_rd.right : node_rd.left;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (operation == OP_FREQ)
                    begin
                        if (do_leaf)
                        begin
                            state_next = S_PUSH_CHK;
                        end
                        else if (last)
                        begin
                            state_next = S_BUILD;
                        end
                    end
                    else if (tree_ready_reg)
                    begin
                        state_next = root_leaf_reg ? S_EMIT : S_DEC_NX;
                    end
                end
            end
            S_PUSH_CHK, S_PUSH_CMP:
            begin
                if (push_done)
                begin
                    state_next = building_reg ? S_BUILD : S_IDLE;
                end
                else
                begin
                    state_next = (state_reg == S_PUSH_CHK) ? S_PUSH_CMP : S_PUSH_CHK;
                end
            end
            S_BUILD:
            begin
                state_next = (hc_reg == '0) ? S_EMIT : S_POP_RD;
            end
            S_POP_RD:
            begin
                state_next = S_POP_LD;
            end
            S_POP_LD:
            begin
                state_next = S_SD_RD;
            end
            S_SD_RD, S_SD_CMP:
            begin
                if (pop_done)
                begin
                    case (pop_reg)
                        POP_A:   state_next = S_POP_RD;
                        POP_B:   state_next = S_MERGE;
                        default: state_next = S_EMIT;
                    endcase
                end
                else
                begin
                    state_next = (state_reg == S_SD_RD) ? S_SD_CMP : S_SD_RD;
                end
            end
            S_MERGE:
            begin
                state_next = S_PUSH_CHK;
            end
            S_DEC_NX:
            begin
                state_next = S_DEC_LF;
            end
            S_DEC_LF:
            begin
                state_next = node_rd.leaf ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pop_next        = pop_reg;
        hc_next         = hc_reg;
        nc_next         = nc_reg;
        root_next       = root_reg;
        walk_next       = walk_reg;
        nxt_next        = nxt_reg;
        tree_ready_next = tree_ready_reg;
        loading_next    = loading_reg;
        cap_next        = cap_reg;
        building_next   = building_reg;
        root_leaf_next  = root_leaf_reg;
        leaf_sym_next   = leaf_sym_reg;
        bit_next        = bit_reg;
        lastb_next      = lastb_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        top_next        = top_reg;
        a_next          = a_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        res_sym_next    = res_sym_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_sym_next    = out_sym_reg;

        heap_ctl    = '0;
        heap_wdata  = val_reg;
        node_we     = 1'b0;
        node_waddr  = nc_reg[NODE_AW-1:0];
        node_wdata  = '0;
        node_raddr  = walk_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (acc && (operation == OP_FREQ))
                begin
                    // first entry of a load starts fresh
                    if (!loading_reg)
                    begin
                        tree_ready_next = 1'b0;
                    end
                    loading_next = 1'b1;
                    hc_next      = hc_eff;
                    nc_next      = nc_eff;
                    cap_next     = loading_reg && cap_reg;
                    if (do_leaf)
                    begin
                        node_we         = 1'b1;
                        node_waddr      = nc_eff[NODE_AW-1:0];
                        node_wdata.leaf = 1'b1;
                        node_wdata.sym  = symbol;
                        leaf_sym_next   = symbol;
                        val_next        = {freq_w, nc_eff[NODE_AW-1:0]};
                        idx_next        = hc_eff[HEAP_AW-1:0];
                        hc_next         = hc_eff + HCNT_W'(1);
                        nc_next         = nc_eff + NCNT_W'(1);
                    end
                    else if (frequency != '0)
                    begin
                        cap_next = 1'b1;
                    end
                    if (last)
                    begin
                        loading_next  = 1'b0;
                        building_next = 1'b1;
                    end
                end
                else if (acc && tree_ready_reg)
                begin
                    bit_next   = coded_bit;
                    lastb_next = last;
                    if (root_leaf_reg)
                    begin
                        res_kind_next   = KIND_SYMBOL;
                        res_status_next = STATUS_BUILT;
                        res_sym_next    = leaf_sym_reg;
                        walk_next       = root_reg;
                    end
                end
            end
            S_PUSH_CHK:
            begin
                heap_ctl.raddr_a = parent;
                if (idx_reg == '0)
                begin
                    heap_ctl.we    = 1'b1;
                    heap_ctl.waddr = idx_reg;
                end
            end
            S_PUSH_CMP:
            begin
                heap_ctl.we    = 1'b1;
                heap_ctl.waddr = idx_reg;
                if (push_up)
                begin
                    heap_wdata = heap_rd_a;
                    idx_next   = parent;
                end
            end
            S_BUILD:
            begin
                if (hc_reg == '0)
                begin
                    tree_ready_next = 1'b0;
                    building_next   = 1'b0;
                    res_kind_next   = KIND_BUILD;
                    res_status_next = STATUS_EMPTY;
                    res_sym_next    = '0;
                end
                else
                begin
                    pop_next = (hc_reg > HCNT_W'(1)) ? POP_A : POP_ROOT;
                end
            end
            S_POP_RD:
            begin
                heap_ctl.raddr_a = '0;
                heap_ctl.raddr_b = HEAP_AW'(hc_reg - HCNT_W'(1));
                hc_next          = hc_reg - HCNT_W'(1);
            end
            S_POP_LD:
            begin
                top_next = heap_rd_a;
                val_next = heap_rd_b;
                idx_next = '0;
            end
            S_SD_RD:
            begin
                heap_ctl.raddr_a = sd_l[HEAP_AW-1:0];
                heap_ctl.raddr_b = sd_r[HEAP_AW-1:0];
                if (sd_leaf)
                begin
                    heap_ctl.we    = 1'b1;
                    heap_ctl.waddr = idx_reg;
                end
            end
            S_SD_CMP:
            begin
                heap_ctl.we    = 1'b1;
                heap_ctl.waddr = idx_reg;
                if (sel_r)
                begin
                    heap_wdata = heap_rd_b;
                    idx_next   = sd_r[HEAP_AW-1:0];
                end
                else if (sel_l)
                begin
                    heap_wdata = heap_rd_a;
                    idx_next   = sd_l[HEAP_AW-1:0];
                end
            end
            S_MERGE:
            begin
                node_we          = 1'b1;
                node_wdata.left  = a_reg[NODE_AW-1:0];
                node_wdata.right = top_reg[NODE_AW-1:0];
                val_next         = {sum_w, nc_reg[NODE_AW-1:0]};
                idx_next         = hc_reg[HEAP_AW-1:0];
                hc_next          = hc_reg + HCNT_W'(1);
                nc_next          = nc_reg + NCNT_W'(1);
            end
            S_DEC_NX:
            begin
                node_raddr = child;
                nxt_next   = child;
            end
            S_DEC_LF:
            begin
                if (node_rd.leaf)
                begin
                    res_kind_next   = KIND_SYMBOL;
                    res_status_next = STATUS_BUILT;
                    res_sym_next    = node_rd.sym;
                    walk_next       = root_reg;
                end
                else
                begin
                    walk_next = nxt_reg;
                end
                if (lastb_reg)
                begin
                    walk_next = root_reg;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = res_kind_reg;
                    out_status_next = res_status_reg;
                    out_sym_next    = res_sym_reg;
                end
            end
            default:
            begin
            end
        endcase

        // finish of a pop: hand the popped entry to the build step, or finish the tree on the root pop
        if (pop_done)
        begin
            case (pop_reg)
                POP_A:
                begin
                    a_next   = top_reg;
                    pop_next = POP_B;
                end
                POP_B:
                begin
                end
                default:
                begin
                    root_next       = top_reg[NODE_AW-1:0];
                    walk_next       = top_reg[NODE_AW-1:0];
                    tree_ready_next = 1'b1;
                    root_leaf_next  = (nc_reg == NCNT_W'(1));
                    building_next   = 1'b0;
                    res_kind_next   = KIND_BUILD;
                    res_status_next = cap_reg ? STATUS_DROPPED : STATUS_BUILT;
                    res_sym_next    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pop_reg        <= POP_A;
            hc_reg         <= '0;
            nc_reg         <= '0;
            root_reg       <= '0;
            walk_reg       <= '0;
            nxt_reg        <= '0;
            tree_ready_reg <= 1'b0;
            loading_reg    <= 1'b0;
            cap_reg        <= 1'b0;
            building_reg   <= 1'b0;
            root_leaf_reg  <= 1'b0;
            leaf_sym_reg   <= '0;
            bit_reg        <= 1'b0;
            lastb_reg      <= 1'b0;
            idx_reg        <= '0;
            val_reg        <= '0;
            top_reg        <= '0;
            a_reg          <= '0;
            res_kind_reg   <= KIND_BUILD;
            res_status_reg <= STATUS_BUILT;
            res_sym_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_BUILD;
            out_status_reg <= STATUS_BUILT;
            out_sym_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pop_reg        <= pop_next;
            hc_reg         <= hc_next;
            nc_reg         <= nc_next;
            root_reg       <= root_next;
            walk_reg       <= walk_next;
            nxt_reg        <= nxt_next;
            tree_ready_reg <= tree_ready_next;
            loading_reg    <= loading_next;
            cap_reg        <= cap_next;
            building_reg   <= building_next;
            root_leaf_reg  <= root_leaf_next;
            leaf_sym_reg   <= leaf_sym_next;
            bit_reg        <= bit_next;
            lastb_reg      <= lastb_next;
            idx_reg        <= idx_next;
            val_reg        <= val_next;
            top_reg        <= top_next;
            a_reg          <= a_next;
            res_kind_reg   <= res_kind_next;
            res_status_reg <= res_status_next;
            res_sym_reg    <= res_sym_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_sym_reg    <= out_sym_next;
        end
    end

`ifndef SYNTHESIS
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hc_reg <= HCNT_W'(HEAP_DEPTH))
        else $error("heap count beyond heap depth");

    a_root_leaf: assert property (@(posedge clk) disable iff (!rst_n)
        tree_ready_reg |-> (root_leaf_reg == (nc_reg == NCNT_W'(1))))
        else $error("root leaf flag disagrees with node count");

    a_merge_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (pop_reg == POP_B))
        else $error("merge without two popped nodes");

    a_tree_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tree_ready_reg) |-> (state_reg == S_EMIT) && (res_kind_reg == KIND_BUILD))
        else $error("tree finished without a build report");

    a_no_load_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        building_reg |-> !loading_reg && !tree_ready_reg)
        else $error("build overlaps a load or a ready tree");
`endif

endmodule

/* rtl/htb_heap_mem.sv */
module htb_heap_mem
    import htb_pkg::*;
#(
    parameter int ENTRY_W = DEF_WEIGHT_BITS + NODE_AW
)(
    input  logic               clk,
    input  heap_ctl_t          ctl,
    input  logic [ENTRY_W-1:0] wdata,
    output logic [ENTRY_W-1:0] rdata_a,
    output logic [ENTRY_W-1:0] rdata_b
);

    logic [ENTRY_W-1:0] mem [HEAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr] <= wdata;
        end
        rdata_a <= mem[ctl.raddr_a];
        rdata_b <= mem[ctl.raddr_b];
    end

endmodule
